/* hw/rtl/yuvlut_pkg.sv */
// Shared types, constants and helpers for the YUV to RGB converter with color table.
// No dependencies; the files that use it refer to it by scoped names.
package yuvlut_pkg;

  // Default grid points per color axis of the lookup table.
  localparam int unsigned LUT_POINTS_DEF = 33;

  // Width of the table address field on the input port.
  localparam int unsigned LUT_ADDR_W = 16;

  // Depths of the queue between front and back, and of the result queue.
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic {
    REQ_PIXEL    = 1'b0,
    REQ_LUT_LOAD = 1'b1
  } req_type_e;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic                  load;   // table write, no result
    logic                  wr_ok;  // write address lies inside the table
    logic [LUT_ADDR_W-1:0] addr;   // table address (write or read)
    logic [23:0]           color;  // blue 23:16, green 15:8, red 7:0
  } item_t;

  // Clamp a signed channel value to 0..255.
  function automatic logic [7:0] clamp8(input logic signed [19:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 20'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/yuvlut_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module yuvlut_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/yuvlut_fifo.sv */
// Small synchronous queue in flip-flops, used between front and back and for results.
// No dependencies.
module yuvlut_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/yuvlut_front.sv */
// Front end: accept requests, convert YUV to RGB, quantize and form the table address.
// Depends on yuvlut_pkg.
module yuvlut_front #(
  parameter int unsigned LUT_POINTS = yuvlut_pkg::LUT_POINTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic                              req_type_i,
  input  logic [7:0]                        luma_i,
  input  logic [7:0]                        chroma_u_i,
  input  logic [7:0]                        chroma_v_i,
  input  logic [yuvlut_pkg::LUT_ADDR_W-1:0] lut_address_i,
  input  logic [7:0]                        lut_red_i,
  input  logic [7:0]                        lut_green_i,
  input  logic [7:0]                        lut_blue_i,
  output logic                              item_valid_o,
  output yuvlut_pkg::item_t                 item_o,
  input  logic                              item_ready_i
);

  localparam int unsigned AW   = yuvlut_pkg::LUT_ADDR_W;
  localparam int unsigned IW   = $clog2(LUT_POINTS);
  localparam int unsigned BG_W = $clog2(LUT_POINTS * LUT_POINTS);
  localparam int unsigned CUBE = LUT_POINTS * LUT_POINTS * LUT_POINTS;

  // Index = ch*(P-1)/255, with the divide done as (x + x/256 + 1)/256.
  function automatic logic [IW-1:0] quant(input logic [7:0] ch);
    logic [15:0] x;
    logic [16:0] s;
    x = 16'(ch) * 16'(LUT_POINTS - 1);
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return IW'(s >> 8);
  endfunction

  logic advance, accept;

  // Stage 1: products
  logic                v1_q, load1_q;
  logic signed [17:0]  y1_q, re1_q, gd1_q, ge1_q, bd1_q;
  logic [AW-1:0]       addr1_q;
  logic [23:0]         lcol1_q;
  logic signed [17:0]  c_s, d_s, e_s;
  // Stage 2: clamped color
  logic                v2_q, load2_q;
  logic [AW-1:0]       addr2_q;
  logic [23:0]         col2_q, col2_d;
  logic signed [19:0]  sum_r, sum_g, sum_b;
  logic signed [19:0]  sh_r, sh_g, sh_b;
  // Stage 3: grid indices
  logic                v3_q, load3_q;
  logic [AW-1:0]       addr3_q;
  logic [23:0]         col3_q;
  logic [IW-1:0]       qr3_q, qg3_q, qb3_q;
  // Stage 4: blue/green row
  logic                v4_q, load4_q;
  logic [AW-1:0]       addr4_q;
  logic [23:0]         col4_q;
  logic [BG_W-1:0]     bg4_q;
  logic [IW-1:0]       qr4_q;
  // Stage 5: finished item
  logic                v5_q;
  yuvlut_pkg::item_t   item5_q, item5_d;

  assign advance = !v5_q || item_ready_i;
  assign full_o  = !advance;
  assign accept  = push_i && advance;

  assign c_s = $signed({10'd0, luma_i}) - 18'sd16;
  assign d_s = $signed({10'd0, chroma_u_i}) - 18'sd128;
  assign e_s = $signed({10'd0, chroma_v_i}) - 18'sd128;

  assign sum_r = 20'(y1_q) + 20'(re1_q) + 20'sd128;
  assign sum_g = 20'(y1_q) - 20'(gd1_q) - 20'(ge1_q) + 20'sd128;
  assign sum_b = 20'(y1_q) + 20'(bd1_q) + 20'sd128;
  assign sh_r  = sum_r >>> 8;
  assign sh_g  = sum_g >>> 8;
  assign sh_b  = sum_b >>> 8;

  assign col2_d = load1_q ? lcol1_q
                          : {yuvlut_pkg::clamp8(sh_b), yuvlut_pkg::clamp8(sh_g),
                             yuvlut_pkg::clamp8(sh_r)};

  always_comb begin
    item5_d.load  = load4_q;
    item5_d.color = col4_q;
    item5_d.wr_ok = (32'(addr4_q) < CUBE);
    if (load4_q) begin
      item5_d.addr = addr4_q;
    end else begin
      item5_d.addr = AW'(32'(bg4_q) * LUT_POINTS + 32'(qr4_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (advance) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      load1_q <= (req_type_i == yuvlut_pkg::REQ_LUT_LOAD);
      y1_q    <= c_s * 18'sd298;
      re1_q   <= e_s * 18'sd409;
      gd1_q   <= d_s * 18'sd100;
      ge1_q   <= e_s * 18'sd208;
      bd1_q   <= d_s * 18'sd516;
      addr1_q <= lut_address_i;
      lcol1_q <= {lut_blue_i, lut_green_i, lut_red_i};

      load2_q <= load1_q;
      addr2_q <= addr1_q;
      col2_q  <= col2_d;

      load3_q <= load2_q;
      addr3_q <= addr2_q;
      col3_q  <= col2_q;
      qr3_q   <= quant(col2_q[7:0]);
      qg3_q   <= quant(col2_q[15:8]);
      qb3_q   <= quant(col2_q[23:16]);

      load4_q <= load3_q;
      addr4_q <= addr3_q;
      col4_q  <= col3_q;
      bg4_q   <= BG_W'(32'(qb3_q) * LUT_POINTS + 32'(qg3_q));
      qr4_q   <= qr3_q;

      item5_q <= item5_d;
    end
  end

  assign item_valid_o = v5_q;
  assign item_o       = item5_q;

endmodule

/* hw/rtl/yuvlut_back.sv */
// Back end: write or read the color table and queue finished pixels.
// Depends on yuvlut_pkg, yuvlut_ram and yuvlut_fifo.
module yuvlut_back #(
  parameter int unsigned LUT_POINTS = yuvlut_pkg::LUT_POINTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              lut_enable_i,
  input  logic              item_valid_i,
  input  yuvlut_pkg::item_t item_i,
  output logic              item_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [31:0]       packed_pixel_o
);

  localparam int unsigned CUBE  = LUT_POINTS * LUT_POINTS * LUT_POINTS;
  localparam int unsigned SPAN  = 1 << yuvlut_pkg::LUT_ADDR_W;
  // Entries beyond the address port's reach can never be written.
  localparam int unsigned DEPTH = (CUBE > SPAN) ? SPAN : CUBE;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic        advance, take_pix, ram_we, ram_re;
  logic [23:0] ram_rdata, res_color;
  logic        b1_v_q, b1_lut_q;
  logic [23:0] b1_col_q;
  logic        out_full;

  assign advance    = !b1_v_q || !out_full;
  assign item_pop_o = item_valid_i && advance;
  assign take_pix   = item_pop_o && !item_i.load;
  assign ram_we     = item_pop_o && item_i.load && item_i.wr_ok;
  assign ram_re     = take_pix && lut_enable_i;

  yuvlut_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_lut_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_i.addr[AW-1:0]),
    .wdata_i (item_i.color),
    .re_i    (ram_re),
    .raddr_i (item_i.addr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
    end else if (advance) begin
      b1_v_q <= take_pix;
    end
  end

  // Hold the pass-through color and the table select with the read in flight.
  always_ff @(posedge clk_i) begin
    if (take_pix) begin
      b1_lut_q <= lut_enable_i;
      b1_col_q <= item_i.color;
    end
  end

  assign res_color = b1_lut_q ? ram_rdata : b1_col_q;

  logic [23:0] out_color;

  yuvlut_fifo #(
    .WIDTH (24),
    .DEPTH (yuvlut_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b1_v_q),
    .wdata_i (res_color),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .rdata_o (out_color),
    .empty_o (empty_o)
  );

  assign packed_pixel_o = {yuvlut_pkg::ALPHA_OPAQUE, out_color};

endmodule

/* hw/rtl/yuv_to_rgb_with_color_lut.sv */
// BT.601 YUV to RGB converter with optional 3D color table; top level.
// Throughput: one request per clock while full is low; a pixel result passes through
// five front stages, the middle queue, the table read register and the result queue.
// Reset clears all valid state and lut_enable; table contents stay undefined until written,
// so there is no clearing pass. Depends on yuvlut_pkg, yuvlut_front, yuvlut_fifo, yuvlut_back.
module yuv_to_rgb_with_color_lut #(
  parameter int unsigned LUT_POINTS = yuvlut_pkg::LUT_POINTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: lut_enable
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  // request side
  input  logic                              push,
  output logic                              full,
  input  logic                              req_type_i,
  input  logic [7:0]                        luma_i,
  input  logic [7:0]                        chroma_u_i,
  input  logic [7:0]                        chroma_v_i,
  input  logic [yuvlut_pkg::LUT_ADDR_W-1:0] lut_address_i,
  input  logic [7:0]                        lut_red_i,
  input  logic [7:0]                        lut_green_i,
  input  logic [7:0]                        lut_blue_i,
  // result side
  output logic                              empty,
  input  logic                              pop,
  output logic [31:0]                       packed_pixel_o
);

  localparam int unsigned ITEM_W = $bits(yuvlut_pkg::item_t);

  logic              lut_enable_q;
  logic              item_valid, mid_full, mid_empty, mid_pop;
  yuvlut_pkg::item_t front_item, mid_item;
  logic [ITEM_W-1:0] mid_rdata;

  // Configuration writes must arrive only while the block is idle, a user duty left unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lut_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      lut_enable_q <= cfg_wdata_i;
    end
  end

  // The front takes requests unless full, runs the color matrix and builds the table address.
  yuvlut_front #(
    .LUT_POINTS (LUT_POINTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .luma_i        (luma_i),
    .chroma_u_i    (chroma_u_i),
    .chroma_v_i    (chroma_v_i),
    .lut_address_i (lut_address_i),
    .lut_red_i     (lut_red_i),
    .lut_green_i   (lut_green_i),
    .lut_blue_i    (lut_blue_i),
    .item_valid_o  (item_valid),
    .item_o        (front_item),
    .item_ready_i  (!mid_full)
  );

  // Decouple the front pipeline from table access so each side stalls on its own.
  yuvlut_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (yuvlut_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_valid),
    .wdata_i (front_item),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_item = yuvlut_pkg::item_t'(mid_rdata);

  // Back: perform table writes, table reads and queue results for the consumer.
  yuvlut_back #(
    .LUT_POINTS (LUT_POINTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lut_enable_i   (lut_enable_q),
    .item_valid_i   (!mid_empty),
    .item_i         (mid_item),
    .item_pop_o     (mid_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .packed_pixel_o (packed_pixel_o)
  );

`ifndef SYNTH
  // Back-pressure reaches the request port only through a blocked front output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (item_valid && mid_full))
    else $error("full raised without a blocked front item");

  // A front item that cannot enter the middle queue must stay presented.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && mid_full) |=> item_valid)
    else $error("front dropped a stalled item");

  // The back only takes requests that the middle queue really holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("back popped an empty middle queue");
`endif

endmodule

/* tb/yuv_to_rgb_with_color_lut_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for yuv_to_rgb_with_color_lut: BT.601 conversion and color table.
// Depends on yuvlut_pkg and the RTL top level; keeps its own table image to predict results.
module yuv_to_rgb_with_color_lut_test;

  localparam int GRID          = yuvlut_pkg::LUT_POINTS_DEF;
  localparam int TABLE_DEPTH   = GRID * GRID * GRID;
  // Idle time after the last result so trailing table writes can land.
  localparam int SETTLE_CYCLES = 12;
  // Cycles with no request or result moving before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        push;
  logic        full;
  logic        req_type_i;
  logic [7:0]  luma_i;
  logic [7:0]  chroma_u_i;
  logic [7:0]  chroma_v_i;
  logic [yuvlut_pkg::LUT_ADDR_W-1:0] lut_address_i;
  logic [7:0]  lut_red_i;
  logic [7:0]  lut_green_i;
  logic [7:0]  lut_blue_i;
  logic        empty;
  logic        pop;
  logic [31:0] packed_pixel_o;

  yuv_to_rgb_with_color_lut #(
    .LUT_POINTS(GRID)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .luma_i        (luma_i),
    .chroma_u_i    (chroma_u_i),
    .chroma_v_i    (chroma_v_i),
    .lut_address_i (lut_address_i),
    .lut_red_i     (lut_red_i),
    .lut_green_i   (lut_green_i),
    .lut_blue_i    (lut_blue_i),
    .empty         (empty),
    .pop           (pop),
    .packed_pixel_o(packed_pixel_o)
  );

  // Predictor state: a mirror of the color table, which entries hold a value,
  // and the current lut_enable setting.
  logic [23:0]  color_table [TABLE_DEPTH];
  bit           table_written [TABLE_DEPTH];
  bit           lut_on;
  logic [31:0]  expected_pixels [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int results_checked;
  int pixels_sent;
  int loads_sent;
  int loads_dropped;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] sat_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // BT.601 integer matrix; >>> on a signed int is a floor shift.
  // Returns blue 23:16, green 15:8, red 7:0.
  function automatic logic [23:0] bt601_rgb(input logic [7:0] y, u, v);
    int c, d, e;
    c = int'(y) - 16;
    d = int'(u) - 128;
    e = int'(v) - 128;
    return {sat_byte((298 * c + 516 * d + 128) >>> 8),
            sat_byte((298 * c - 100 * d - 208 * e + 128) >>> 8),
            sat_byte((298 * c + 409 * e + 128) >>> 8)};
  endfunction

  // Table entry picked by a converted color: each channel scaled down to a grid
  // index with truncation, blue the slowest axis and red the fastest.
  function automatic int grid_addr(input logic [23:0] rgb);
    int ri, gi, bi;
    ri = int'(rgb[7:0]) * (GRID - 1) / 255;
    gi = int'(rgb[15:8]) * (GRID - 1) / 255;
    bi = int'(rgb[23:16]) * (GRID - 1) / 255;
    return (bi * GRID + gi) * GRID + ri;
  endfunction

  function automatic logic [31:0] predict_pixel(input logic [7:0] y, u, v);
    logic [23:0] rgb;
    rgb = bt601_rgb(y, u, v);
    if (lut_on) rgb = color_table[grid_addr(rgb)];
    return {yuvlut_pkg::ALPHA_OPAQUE, rgb};
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random pop, and the scoreboard check on every accepted result
  // ---------------------------------------------------------------------------

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      pop = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    logic [31:0] want;
    if (rst_ni && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $error("packed_pixel: no result expected, got %h", packed_pixel_o);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (packed_pixel_o !== want) begin
          $error("packed_pixel: expected %h, got %h", want, packed_pixel_o);
          mismatches++;
        end
      end
    end
  end

  // Hang detector: count cycles in which neither side hands anything over.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Stalled for %0d cycles with %0d results outstanding",
             STALL_LIMIT, expected_pixels.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Send one request. Called at a falling edge, returns at a falling edge with
  // push still high so that back-to-back requests need no extra edge on push.
  task automatic send_req(input yuvlut_pkg::req_type_e kind, input logic [7:0] y, u, v,
                          input logic [15:0] addr, input logic [7:0] r, g, b);
    // Random sender gaps; drop push while idling.
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push          = 1'b1;
    req_type_i    = kind;
    luma_i        = y;
    chroma_u_i    = u;
    chroma_v_i    = v;
    lut_address_i = addr;
    lut_red_i     = r;
    lut_green_i   = g;
    lut_blue_i    = b;
    // Hold the request until an edge sees full low.
    do @(posedge clk_i); while (full);
    // Accepted at this edge: advance the predictor in request order.
    if (kind == yuvlut_pkg::REQ_LUT_LOAD) begin
      loads_sent++;
      if (int'(addr) < TABLE_DEPTH) begin
        color_table[addr]   = {b, g, r};
        table_written[addr] = 1'b1;
      end else begin
        loads_dropped++;
      end
    end else begin
      pixels_sent++;
      expected_pixels.push_back(predict_pixel(y, u, v));
    end
    @(negedge clk_i);
  endtask

  // Table write; the pixel fields carry noise the block has to ignore.
  task automatic send_load(input logic [15:0] addr, input logic [7:0] r, g, b);
    send_req(yuvlut_pkg::REQ_LUT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
             addr, r, g, b);
  endtask

  // Pixel request. With the table applied, an entry that was never written must
  // not be read, so load it with a random color first.
  task automatic send_pixel(input logic [7:0] y, u, v);
    int a;
    a = grid_addr(bt601_rgb(y, u, v));
    if (lut_on && !table_written[a]) begin
      send_load(16'(a), 8'($urandom), 8'($urandom), 8'($urandom));
    end
    send_req(yuvlut_pkg::REQ_PIXEL, y, u, v, 16'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom));
  endtask

  // Hold off the sender until every expected result has come back, then give
  // trailing table writes time to land.
  task automatic wait_drained();
    push = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // lut_enable may only change while the block is idle.
  task automatic set_lut_enable(input bit enable);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = enable;
    @(posedge clk_i);
    lut_on = enable;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Table bypassed: black, white, field extremes and clamping on both ends.
  task automatic test_convert_extremes();
    set_lut_enable(1'b0);
    send_pixel(8'd16, 8'd128, 8'd128);   // black, zero offsets
    send_pixel(8'd235, 8'd128, 8'd128);  // nominal white
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd16, 8'd0, 8'd255);     // blue and green clamp low, red stays in range
    send_pixel(8'd16, 8'd255, 8'd0);
    send_pixel(8'd16, 8'd128, 8'd127);   // small negative sum, floor then clamp
    send_pixel(8'd128, 8'd127, 8'd129);
  endtask

  // Table loads at both ends, writes past the table end, overwrite followed
  // at once by a read of the same entry, and reads through the table.
  task automatic test_table_access();
    send_load(16'd0, 8'h11, 8'h22, 8'h33);
    send_load(16'(TABLE_DEPTH - 1), 8'hA5, 8'h5A, 8'hFF);
    // Out of range: both must be dropped without touching any entry.
    send_load(16'(TABLE_DEPTH), 8'hDE, 8'hAD, 8'hBE);
    send_load(16'hFFFF, 8'hEF, 8'h01, 8'h02);
    set_lut_enable(1'b1);
    send_pixel(8'd16, 8'd128, 8'd128);   // reads entry 0
    send_pixel(8'd255, 8'd128, 8'd128);  // reads the last entry
    send_load(16'd0, 8'h00, 8'hFF, 8'h80);
    send_pixel(8'd16, 8'd128, 8'd128);   // must see the fresh value
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd81, 8'd90, 8'd240);
  endtask

  // Random traffic: mostly pixels, a share of table writes (some out of range),
  // and lut_enable flipped halfway. Every accepted request counts toward n,
  // table fills ahead of pixels included.
  task automatic test_random_traffic(input int send_pct, recv_pct, input bit first_en,
                                     input int n);
    int base;
    logic [15:0] a;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_lut_enable(first_en);
    base = pixels_sent + loads_sent;
    while (pixels_sent + loads_sent - base < n) begin
      if (pixels_sent + loads_sent - base >= n / 2 && lut_on == first_en) begin
        set_lut_enable(!first_en);
      end
      if ($urandom_range(99) < 20) begin
        if ($urandom_range(99) < 15) a = 16'($urandom_range(65535));
        else a = 16'($urandom_range(TABLE_DEPTH - 1));
        send_load(a, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    push          = 1'b0;
    req_type_i    = yuvlut_pkg::REQ_PIXEL;
    luma_i        = '0;
    chroma_u_i    = '0;
    chroma_v_i    = '0;
    lut_address_i = '0;
    lut_red_i     = '0;
    lut_green_i   = '0;
    lut_blue_i    = '0;
    lut_on        = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_convert_extremes();
    test_table_access();
    test_random_traffic(37, 71, 1'b0, 415);
    test_random_traffic(71, 37, 1'b1, 415);
    test_random_traffic(0, 0, 1'b0, 420);

    wait_drained();
    $display("Sent %0d pixels and %0d table writes (%0d past the table end);",
             pixels_sent, loads_sent, loads_dropped);
    $display("checked %0d results with the table bypassed and applied, under stalls.",
             results_checked);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/yuvlut_pkg.sv
hw/rtl/yuvlut_ram.sv
hw/rtl/yuvlut_fifo.sv
hw/rtl/yuvlut_front.sv
hw/rtl/yuvlut_back.sv
hw/rtl/yuv_to_rgb_with_color_lut.sv
tb/yuv_to_rgb_with_color_lut_test.sv
